// ----- sv/dtlv_pkg.sv -----
// Shared types and constants of the DER tag-length encoder.
`timescale 1ns / 1ps
`default_nettype none
package dtlv_pkg;

	// Request kinds on the input stream
	localparam logic REQ_HEADER  = 1'b0;
	localparam logic REQ_PAYLOAD = 1'b1;

	// Result status codes
	localparam logic [1:0] ST_OK         = 2'd0;
	localparam logic [1:0] ST_NO_ROOM    = 2'd1;
	localparam logic [1:0] ST_UNEXPECTED = 2'd2;

	// Encoding constants
	localparam logic [4:0] TAG_LONG_FORM = 5'h1F;
	localparam logic [7:0] LEN_LONG_1    = 8'h81;
	localparam logic [7:0] LEN_LONG_2    = 8'h82;
	localparam logic [7:0] LEN_LONG_4    = 8'h84;
	localparam logic [31:0] LEN_SHORT_LIM = 32'h0000_0080;
	localparam logic [31:0] LEN_1B_LIM    = 32'h0000_0100;
	localparam logic [31:0] LEN_2B_LIM    = 32'h0001_0000;

	// Up to 4 tag bytes and 5 length bytes
	localparam int MAX_HDR = 9;
	localparam int CNT_W   = $clog2(MAX_HDR + 1);

	// One decoded request: the result bytes it causes and their common fields
	typedef struct packed {
		logic [MAX_HDR-1:0][7:0] bytes;
		logic [CNT_W-1:0]        cnt;
		logic                    byte_valid;
		logic [1:0]              status;
		logic [31:0]             total;
	} job_t;

endpackage
`default_nettype wire

// ----- sv/dtlv_hdr_build.sv -----
// Decodes one registered request into its list of result bytes.
`timescale 1ns / 1ps
`default_nettype none
module dtlv_hdr_build (
	input  wire logic         req_type,
	input  wire logic [31:0]  tag_word,
	input  wire logic [31:0]  payload_length,
	input  wire logic [31:0]  space_free,
	input  wire logic [7:0]   data_byte,
	input  wire logic [31:0]  payload_left,
	output dtlv_pkg::job_t    job,
	output logic [31:0]       payload_left_nxt
);
	import dtlv_pkg::*;

	logic [7:0]  b0, b1, b2;
	logic [2:0]  tag_n;
	logic [2:0]  len_n;
	logic [31:0] tag_vec;
	logic [39:0] len_vec;
	logic [71:0] len_sh;
	logic [3:0]  hdr_n;
	logic [32:0] total;
	logic        fits;

	always_comb begin
		b0 = tag_word[7:0];
		b1 = tag_word[15:8];
		b2 = tag_word[23:16];

		// tag size: extend while the long form and continuation bits ask for it
		tag_n = 3'd1;
		if (b0[4:0] == TAG_LONG_FORM) begin
			tag_n = 3'd2;
			if (b1[7]) begin
				tag_n = 3'd3;
				if (b2[7]) begin
					tag_n = 3'd4;
				end
			end
		end
		case (tag_n)
			3'd1:    tag_vec = {24'd0, tag_word[7:0]};
			3'd2:    tag_vec = {16'd0, tag_word[15:0]};
			3'd3:    tag_vec = {8'd0, tag_word[23:0]};
			default: tag_vec = tag_word;
		endcase

		// length bytes, first emitted in the low byte
		if (payload_length < LEN_SHORT_LIM) begin
			len_n   = 3'd1;
			len_vec = {32'd0, payload_length[7:0]};
		end else if (payload_length < LEN_1B_LIM) begin
			len_n   = 3'd2;
			len_vec = {24'd0, payload_length[7:0], LEN_LONG_1};
		end else if (payload_length < LEN_2B_LIM) begin
			len_n   = 3'd3;
			len_vec = {16'd0, payload_length[7:0], payload_length[15:8], LEN_LONG_2};
		end else begin
			len_n   = 3'd5;
			len_vec = {payload_length[7:0], payload_length[15:8],
				payload_length[23:16], payload_length[31:24], LEN_LONG_4};
		end

		len_sh = {32'd0, len_vec} << {tag_n, 3'b000};
		hdr_n  = {1'b0, tag_n} + {1'b0, len_n};
		total  = {29'd0, hdr_n} + {1'b0, payload_length};
		fits   = total <= {1'b0, space_free};

		job = '0;
		payload_left_nxt = payload_left;
		job.cnt = CNT_W'(1);
		if (req_type == REQ_PAYLOAD) begin
			if (payload_left == 32'd0) begin
				job.status = ST_UNEXPECTED;
			end else begin
				job.byte_valid   = 1'b1;
				job.bytes[0]     = data_byte;
				payload_left_nxt = payload_left - 32'd1;
			end
		end else begin
			job.total = total[32] ? 32'hFFFF_FFFF : total[31:0];
			if (fits) begin
				job.bytes        = len_sh | {40'd0, tag_vec};
				job.cnt          = CNT_W'(hdr_n);
				job.byte_valid   = 1'b1;
				payload_left_nxt = payload_length;
			end else begin
				job.status       = ST_NO_ROOM;
				payload_left_nxt = 32'd0;
			end
		end
	end

endmodule
`default_nettype wire

// ----- sv/dtlv_serializer.sv -----
// Holds one decoded request and emits its bytes one per cycle into the output register unless the output stalls.
`timescale 1ns / 1ps
`default_nettype none
module dtlv_serializer (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	input  wire dtlv_pkg::job_t in_job,
	output logic              in_ready,
	output logic              out_valid,
	input  wire logic         out_ready,
	output logic [7:0]        out_byte,
	output logic              out_byte_valid,
	output logic              out_last,
	output logic [1:0]        out_status,
	output logic [31:0]       out_total
);
	import dtlv_pkg::*;

	job_t             job_s2;
	logic             job_v_s2;
	logic [CNT_W-1:0] idx_q;
	logic             out_v_s3;
	logic [7:0]       byte_s3;
	logic             bvalid_s3;
	logic             last_s3;
	logic [1:0]       status_s3;
	logic [31:0]      total_s3;
	logic             out_load;
	logic             emit;
	logic             at_last;
	logic             job_done;

	assign out_load = !out_v_s3 || out_ready;
	assign emit     = job_v_s2 && out_load;
	assign at_last  = idx_q == (job_s2.cnt - CNT_W'(1));
	assign job_done = emit && at_last;
	assign in_ready = !job_v_s2 || job_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_v_s2 <= 1'b0;
			idx_q    <= '0;
		end else if (in_valid && in_ready) begin
			job_v_s2 <= 1'b1;
			idx_q    <= '0;
		end else if (job_done) begin
			job_v_s2 <= 1'b0;
		end else if (emit) begin
			idx_q <= idx_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			job_s2 <= in_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_s3 <= 1'b0;
		end else if (emit) begin
			out_v_s3 <= 1'b1;
		end else if (out_ready) begin
			out_v_s3 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			byte_s3   <= job_s2.bytes[idx_q];
			bvalid_s3 <= job_s2.byte_valid;
			last_s3   <= at_last;
			status_s3 <= job_s2.status;
			total_s3  <= job_s2.total;
		end
	end

	assign out_valid      = out_v_s3;
	assign out_byte       = byte_s3;
	assign out_byte_valid = bvalid_s3;
	assign out_last       = last_s3;
	assign out_status     = status_s3;
	assign out_total      = total_s3;

	// the byte index never runs past the request's byte count
	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		job_v_s2 |-> (idx_q < job_s2.cnt))
		else $error("byte index beyond request byte count");

	// a non-first byte only follows a request that was already held
	a_idx_continues: assert property (@(posedge clk) disable iff (!arst_n)
		(job_v_s2 && idx_q != '0) |-> $past(job_v_s2))
		else $error("byte index advanced without a held request");

	// a result without a byte carries a zero byte and an error status
	a_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_s3 && !bvalid_s3) |-> (byte_s3 == 8'd0 && status_s3 != ST_OK && last_s3))
		else $error("empty result with data or ok status");

	// error results end their request at once
	a_err_single: assert property (@(posedge clk) disable iff (!arst_n)
		(job_v_s2 && job_s2.status != ST_OK) |-> (job_s2.cnt == CNT_W'(1)))
		else $error("error request with more than one result");

endmodule
`default_nettype wire

// ----- sv/der_tlv_header_encoder_core.sv -----
// Top level of the DER tag-length-value encoder core.
`timescale 1ns / 1ps
`default_nettype none
// DER element encoder. A header request (tuser 0) carries the tag word, the payload
// length and the free output space; the core emits 1 to 4 tag bytes and a 1, 2, 3 or
// 5 byte DER length, one byte per output beat with tlast on the final one, then lets
// that many payload requests (tuser 1) pass through, one byte each. If the whole
// element does not fit, a single beat with no byte and status 1 reports the needed
// total instead. A payload byte with no payload expected gives a single beat with
// status 2. tlast marks the last output beat of every request. A header request
// holds the byte serializer until all of its header bytes (2 to 9) are out, while
// payload requests and error beats give one beat each; the next request is taken
// in the cycle of its last byte. An input passes the input register, the serializer's
// request register and the output register before its first output beat. A header
// arriving mid-payload drops the rest of the earlier element.
module der_tlv_header_encoder_core (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [103:0] s_tdata,  // tag_word, payload_length, space_free, data_byte
	input  wire logic         s_tuser,  // req_type
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [39:0]       m_tdata,  // out_byte, total_length
	output logic [2:0]        m_tuser,  // byte_valid, status
	output logic              m_tlast
);
	import dtlv_pkg::*;

	// input register
	logic        in_v_s1;
	logic        type_s1;
	logic [31:0] tag_s1;
	logic [31:0] plen_s1;
	logic [31:0] space_s1;
	logic [7:0]  data_s1;

	logic [31:0] payload_left_q;
	logic [31:0] payload_left_nxt;
	job_t        job;
	logic        ser_ready;
	logic        take;

	logic [7:0]  out_byte;
	logic        out_bvalid;
	logic [1:0]  out_status;
	logic [31:0] out_total;

	assign take     = in_v_s1 && ser_ready;
	assign s_tready = !in_v_s1 || ser_ready;

	// hold the request until the serializer takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_v_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			in_v_s1 <= 1'b1;
		end else if (take) begin
			in_v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			type_s1  <= s_tuser;
			tag_s1   <= s_tdata[31:0];
			plen_s1  <= s_tdata[63:32];
			space_s1 <= s_tdata[95:64];
			data_s1  <= s_tdata[103:96];
		end
	end

	// advance the payload count as each request enters the serializer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			payload_left_q <= 32'd0;
		end else if (take) begin
			payload_left_q <= payload_left_nxt;
		end
	end

	dtlv_hdr_build u_build (
		.req_type         (type_s1),
		.tag_word         (tag_s1),
		.payload_length   (plen_s1),
		.space_free       (space_s1),
		.data_byte        (data_s1),
		.payload_left     (payload_left_q),
		.job              (job),
		.payload_left_nxt (payload_left_nxt)
	);

	dtlv_serializer u_ser (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_v_s1),
		.in_job         (job),
		.in_ready       (ser_ready),
		.out_valid      (m_tvalid),
		.out_ready      (m_tready),
		.out_byte       (out_byte),
		.out_byte_valid (out_bvalid),
		.out_last       (m_tlast),
		.out_status     (out_status),
		.out_total      (out_total)
	);

	assign m_tdata = {out_total, out_byte};
	assign m_tuser = {out_status, out_bvalid};

	// an unexpected payload byte leaves the count alone
	a_unexp_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		(take && type_s1 == REQ_PAYLOAD && payload_left_q == 32'd0) |=>
		(payload_left_q == 32'd0))
		else $error("unexpected payload byte changed the count");

	// a passed payload byte consumes exactly one count
	a_payload_dec: assert property (@(posedge clk) disable iff (!arst_n)
		(take && type_s1 == REQ_PAYLOAD && payload_left_q != 32'd0) |=>
		(payload_left_q == $past(payload_left_q) - 32'd1))
		else $error("payload count not decremented");

	// payload results carry no total
	a_payload_total: assert property (@(posedge clk) disable iff (!arst_n)
		(take && type_s1 == REQ_PAYLOAD) |-> (job.total == 32'd0))
		else $error("payload result with a total");

endmodule
`default_nettype wire
